// ===== hdl/cfbrb_pkg.sv =====
// Package for the command-framed byte ring buffer.
// Depth, widths, op and status codes, register map and pointer helpers.
// No dependencies.
`default_nettype none

package cfbrb_pkg;

    localparam int DEPTH     = 64;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 8;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;
    localparam int CNT_OUT_W = 7;

    // APB map: one 32-bit register at byte address 0
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_TERMINATOR = REG_IDX_W'(0);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 3'd0,
        OP_POP      = 3'd1,
        OP_POP_CMD  = 3'd2,
        OP_PEEK_OLD = 3'd3,
        OP_PEEK_NEW = 3'd4,
        OP_FLUSH    = 3'd5,
        OP_CMD_LEN  = 3'd6
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] wrap_dec(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == '0)
            r = PTR_W'(DEPTH - 1);
        else
            r = p - PTR_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cfbrb_if.sv =====
// Request and result channel interfaces (valid/ready with payload).
// Depends on cfbrb_pkg.
`default_nettype none

interface cfbrb_in_if;
    import cfbrb_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] data_in;

    modport source (output valid, output op, output data_in, input ready);
    modport sink   (input valid, input op, input data_in, output ready);
endinterface

interface cfbrb_out_if;
    import cfbrb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DATA_W-1:0]    data_out;
    logic [ST_W-1:0]      status;
    logic                 last;
    logic [CNT_OUT_W-1:0] bytes_held;
    logic [CNT_OUT_W-1:0] commands_held;
    logic [CNT_OUT_W-1:0] next_length;

    modport source (output valid, output data_out, output status, output last,
                    output bytes_held, output commands_held, output next_length,
                    input ready);
    modport sink   (input valid, input data_out, input status, input last,
                    input bytes_held, input commands_held, input next_length,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/command_framed_byte_ring_buffer.sv =====
// Command-framed byte ring buffer, top level: sequencer around the byte RAM.
// Depends on cfbrb_pkg, cfbrb_if (cfbrb_in_if, cfbrb_out_if), cfbrb_ram, cfbrb_cfg.
//
// Usage:
//   req  - request channel (op, data_in), taken when valid && ready.
//   rsp  - result channel; one result per request, except pop command, which
//          returns one result per command byte, the terminator as 0, with
//          last set on the final one. bytes_held/commands_held on every
//          result are the counts after the whole request.
//   APB  - terminator register at address 0; write only while idle.
// Timing: one request at a time. Push, flush, unused op: straight to the
//   send state. Pop, peeks: one RAM read, then send. Command length: a scan
//   of k entries (up to DEPTH), one RAM read per cycle, then send. Pop
//   command: the same scan, then one RAM read per returned byte and a closing
//   result; the single read port of the byte RAM serialises these reads.
// A finished result sits in an output register; the next request is taken
// while it waits. If the receiver stalls, the sequencer holds its next
// result and stops. Reset clears positions, counts and the terminator;
// the RAM contents are not cleared.
`default_nettype none

module command_framed_byte_ring_buffer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    cfbrb_in_if.sink                           req,
    cfbrb_out_if.source                        rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cfbrb_pkg::APB_AW-1:0]  paddr,
    input  wire logic [cfbrb_pkg::APB_DW-1:0]  pwdata,
    output logic      [cfbrb_pkg::APB_DW-1:0]  prdata,
    output logic                               pready
);
    import cfbrb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_EMIT_RD,
        S_EMIT_DATA,
        S_SEND
    } state_t;

    typedef enum logic [1:0] {
        TAIL_TERM,
        TAIL_EMPTY,
        TAIL_NONE
    } tail_t;

    logic [DATA_W-1:0] terminator;

    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [PTR_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  cs_reg, cs_next;
    logic [CNT_W-1:0]  bcnt_reg, bcnt_next;
    logic [CNT_W-1:0]  ccnt_reg, ccnt_next;

    logic [PTR_W-1:0]  scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0]  scan_iss_reg, scan_iss_next;
    logic [CNT_W-1:0]  scan_lim_reg, scan_lim_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0]  chk_cnt_reg, chk_cnt_next;

    logic [CNT_W-1:0]  emit_left_reg, emit_left_next;
    tail_t             tail_reg, tail_next;
    logic [CNT_W-1:0]  fin_bcnt_reg, fin_bcnt_next;
    logic [CNT_W-1:0]  fin_ccnt_reg, fin_ccnt_next;

    logic [DATA_W-1:0] res_data_reg, res_data_next;
    logic [ST_W-1:0]   res_status_reg, res_status_next;
    logic              res_last_reg, res_last_next;
    logic [CNT_W-1:0]  res_bcnt_reg, res_bcnt_next;
    logic [CNT_W-1:0]  res_ccnt_reg, res_ccnt_next;
    logic [CNT_W-1:0]  res_len_reg, res_len_next;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic [ST_W-1:0]   out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;
    logic [CNT_W-1:0]  out_bcnt_reg, out_bcnt_next;
    logic [CNT_W-1:0]  out_ccnt_reg, out_ccnt_next;
    logic [CNT_W-1:0]  out_len_reg, out_len_next;

    logic              out_free;
    logic [CNT_W-1:0]  partial;
    logic              hit;
    logic              scan_miss;
    logic [CNT_W-1:0]  chk_len;

    cfbrb_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .terminator (terminator)
    );

    cfbrb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Writes happen only at request acceptance; every read starts in a later
    // cycle or on a request that does not write, so no forwarding is needed.
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    // length of the unterminated tail, modulo depth
    assign partial = (wp_reg >= cs_reg) ? (CNT_W'(wp_reg) - CNT_W'(cs_reg))
                   : (CNT_W'(wp_reg) + CNT_W'(DEPTH) - CNT_W'(cs_reg));

    assign chk_len   = chk_cnt_reg + CNT_W'(1);
    assign hit       = chk_vld_reg && (ram_rdata == terminator);
    assign scan_miss = chk_vld_reg && !hit && (chk_len == scan_lim_reg);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        cs_next         = cs_reg;
        bcnt_next       = bcnt_reg;
        ccnt_next       = ccnt_reg;
        scan_ptr_next   = scan_ptr_reg;
        scan_iss_next   = scan_iss_reg;
        scan_lim_next   = scan_lim_reg;
        chk_vld_next    = chk_vld_reg;
        chk_cnt_next    = chk_cnt_reg;
        emit_left_next  = emit_left_reg;
        tail_next       = tail_reg;
        fin_bcnt_next   = fin_bcnt_reg;
        fin_ccnt_next   = fin_ccnt_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        res_bcnt_next   = res_bcnt_reg;
        res_ccnt_next   = res_ccnt_reg;
        res_len_next    = res_len_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_bcnt_next   = out_bcnt_reg;
        out_ccnt_next   = out_ccnt_reg;
        out_len_next    = out_len_reg;
        ram_we          = 1'b0;
        ram_waddr       = wp_reg;
        ram_wdata       = req.data_in;
        ram_raddr       = rp_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.op;
                    res_data_next   = '0;
                    res_status_next = ST_OK;
                    res_last_next   = 1'b1;
                    res_len_next    = '0;
                    state_next      = S_SEND;
                    case (req.op)
                        OP_PUSH:
                        begin
                            if (bcnt_reg >= CNT_W'(DEPTH))
                            begin
                                bcnt_next       = (partial <= bcnt_reg) ?
                                                  (bcnt_reg - partial) : '0;
                                wp_next         = cs_reg;
                                res_status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                wp_next   = wrap_inc(wp_reg);
                                bcnt_next = bcnt_reg + CNT_W'(1);
                                if (req.data_in == terminator)
                                begin
                                    if (ccnt_reg < CNT_W'(DEPTH))
                                    begin
                                        ccnt_next = ccnt_reg + CNT_W'(1);
                                    end
                                    cs_next = wrap_inc(wp_reg);
                                end
                            end
                        end
                        OP_POP, OP_PEEK_OLD, OP_PEEK_NEW:
                        begin
                            if (bcnt_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                if (req.op == OP_PEEK_NEW)
                                begin
                                    ram_raddr = wrap_dec(wp_reg);
                                end
                                if (req.op == OP_POP)
                                begin
                                    rp_next   = wrap_inc(rp_reg);
                                    bcnt_next = bcnt_reg - CNT_W'(1);
                                end
                                state_next = S_READ;
                            end
                        end
                        OP_POP_CMD:
                        begin
                            if (ccnt_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else if (bcnt_reg == '0)
                            begin
                                emit_left_next = '0;
                                tail_next      = TAIL_EMPTY;
                                fin_bcnt_next  = bcnt_reg;
                                fin_ccnt_next  = ccnt_reg;
                                state_next     = S_EMIT_RD;
                            end
                            else
                            begin
                                scan_ptr_next = rp_reg;
                                scan_iss_next = '0;
                                scan_lim_next = bcnt_reg;
                                chk_vld_next  = 1'b0;
                                state_next    = S_SCAN;
                            end
                        end
                        OP_FLUSH:
                        begin
                            rp_next   = '0;
                            wp_next   = '0;
                            cs_next   = '0;
                            bcnt_next = '0;
                            ccnt_next = '0;
                        end
                        OP_CMD_LEN:
                        begin
                            if (ccnt_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                scan_ptr_next = rp_reg;
                                scan_iss_next = '0;
                                scan_lim_next = CNT_W'(DEPTH);
                                chk_vld_next  = 1'b0;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                    res_bcnt_next = bcnt_next;
                    res_ccnt_next = ccnt_next;
                end
            end

            S_READ:
            begin
                if (op_reg == OP_POP && ram_rdata == terminator && ccnt_reg != '0)
                begin
                    ccnt_next = ccnt_reg - CNT_W'(1);
                end
                res_data_next = ram_rdata;
                res_bcnt_next = bcnt_reg;
                res_ccnt_next = ccnt_next;
                state_next    = S_SEND;
            end

            S_SCAN:
            begin
                if (scan_iss_reg < scan_lim_reg)
                begin
                    ram_raddr     = scan_ptr_reg;
                    scan_ptr_next = wrap_inc(scan_ptr_reg);
                    scan_iss_next = scan_iss_reg + CNT_W'(1);
                    chk_vld_next  = 1'b1;
                    chk_cnt_next  = scan_iss_reg;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
                if (hit || scan_miss)
                begin
                    chk_vld_next = 1'b0;
                    if (op_reg == OP_CMD_LEN)
                    begin
                        res_data_next   = '0;
                        res_status_next = ST_OK;
                        res_last_next   = 1'b1;
                        res_len_next    = hit ? chk_len : '0;
                        res_bcnt_next   = bcnt_reg;
                        res_ccnt_next   = ccnt_reg;
                        state_next      = S_SEND;
                    end
                    else
                    begin
                        if (hit)
                        begin
                            emit_left_next = chk_cnt_reg;
                            tail_next      = TAIL_TERM;
                            fin_bcnt_next  = bcnt_reg - chk_len;
                            fin_ccnt_next  = (ccnt_reg != '0) ?
                                             (ccnt_reg - CNT_W'(1)) : '0;
                        end
                        else
                        begin
                            emit_left_next = bcnt_reg;
                            tail_next      = (bcnt_reg == CNT_W'(DEPTH)) ?
                                             TAIL_NONE : TAIL_EMPTY;
                            fin_bcnt_next  = '0;
                            fin_ccnt_next  = ccnt_reg;
                        end
                        state_next = S_EMIT_RD;
                    end
                end
            end

            S_EMIT_RD:
            begin
                res_len_next  = '0;
                res_bcnt_next = fin_bcnt_reg;
                res_ccnt_next = fin_ccnt_reg;
                if (emit_left_reg != '0)
                begin
                    ram_raddr      = rp_reg;
                    rp_next        = wrap_inc(rp_reg);
                    bcnt_next      = bcnt_reg - CNT_W'(1);
                    emit_left_next = emit_left_reg - CNT_W'(1);
                    state_next     = S_EMIT_DATA;
                end
                else
                begin
                    res_data_next = '0;
                    res_last_next = 1'b1;
                    case (tail_reg)
                        TAIL_TERM:
                        begin
                            rp_next         = wrap_inc(rp_reg);
                            bcnt_next       = bcnt_reg - CNT_W'(1);
                            ccnt_next       = (ccnt_reg != '0) ?
                                              (ccnt_reg - CNT_W'(1)) : '0;
                            res_status_next = ST_OK;
                        end
                        TAIL_EMPTY:
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                    state_next = S_SEND;
                end
            end

            S_EMIT_DATA:
            begin
                res_data_next   = ram_rdata;
                res_status_next = ST_OK;
                res_last_next   = (emit_left_reg == '0) && (tail_reg == TAIL_NONE);
                state_next      = S_SEND;
            end

            S_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = res_data_reg;
                    out_status_next = res_status_reg;
                    out_last_next   = res_last_reg;
                    out_bcnt_next   = res_bcnt_reg;
                    out_ccnt_next   = res_ccnt_reg;
                    out_len_next    = res_len_reg;
                    state_next      = res_last_reg ? S_IDLE : S_EMIT_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            rp_reg         <= '0;
            wp_reg         <= '0;
            cs_reg         <= '0;
            bcnt_reg       <= '0;
            ccnt_reg       <= '0;
            scan_ptr_reg   <= '0;
            scan_iss_reg   <= '0;
            scan_lim_reg   <= '0;
            chk_vld_reg    <= 1'b0;
            chk_cnt_reg    <= '0;
            emit_left_reg  <= '0;
            tail_reg       <= TAIL_NONE;
            fin_bcnt_reg   <= '0;
            fin_ccnt_reg   <= '0;
            res_data_reg   <= '0;
            res_status_reg <= '0;
            res_last_reg   <= 1'b0;
            res_bcnt_reg   <= '0;
            res_ccnt_reg   <= '0;
            res_len_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_status_reg <= '0;
            out_last_reg   <= 1'b0;
            out_bcnt_reg   <= '0;
            out_ccnt_reg   <= '0;
            out_len_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            cs_reg         <= cs_next;
            bcnt_reg       <= bcnt_next;
            ccnt_reg       <= ccnt_next;
            scan_ptr_reg   <= scan_ptr_next;
            scan_iss_reg   <= scan_iss_next;
            scan_lim_reg   <= scan_lim_next;
            chk_vld_reg    <= chk_vld_next;
            chk_cnt_reg    <= chk_cnt_next;
            emit_left_reg  <= emit_left_next;
            tail_reg       <= tail_next;
            fin_bcnt_reg   <= fin_bcnt_next;
            fin_ccnt_reg   <= fin_ccnt_next;
            res_data_reg   <= res_data_next;
            res_status_reg <= res_status_next;
            res_last_reg   <= res_last_next;
            res_bcnt_reg   <= res_bcnt_next;
            res_ccnt_reg   <= res_ccnt_next;
            res_len_reg    <= res_len_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
            out_bcnt_reg   <= out_bcnt_next;
            out_ccnt_reg   <= out_ccnt_next;
            out_len_reg    <= out_len_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.data_out      = out_data_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.last          = out_last_reg;
    assign rsp.bytes_held    = CNT_OUT_W'(out_bcnt_reg);
    assign rsp.commands_held = CNT_OUT_W'(out_ccnt_reg);
    assign rsp.next_length   = CNT_OUT_W'(out_len_reg);

`ifndef SYNTH
    a_bcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (bcnt_reg <= CNT_W'(DEPTH)) && (ccnt_reg <= CNT_W'(DEPTH)))
        else $error("byte or command count above depth");

    a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE && req.valid && req.op == OP_PUSH))
        else $error("store write outside push acceptance");

    a_more_results: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> (state_reg != S_IDLE))
        else $error("idle while a command pop is still open");
`endif

endmodule

`default_nettype wire

// ===== hdl/cfbrb_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cfbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/cfbrb_cfg.sv =====
// APB register block: holds the terminator byte.
// Depends on cfbrb_pkg.
`default_nettype none

module cfbrb_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cfbrb_pkg::APB_AW-1:0]   paddr,
    input  wire logic [cfbrb_pkg::APB_DW-1:0]   pwdata,
    output logic      [cfbrb_pkg::APB_DW-1:0]   prdata,
    output logic                                pready,
    output logic      [cfbrb_pkg::DATA_W-1:0]   terminator
);
    import cfbrb_pkg::*;

    logic [DATA_W-1:0]    term_reg;
    logic [DATA_W-1:0]    term_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        term_next = term_reg;
        if (wr_en && reg_idx == REG_TERMINATOR)
        begin
            term_next = pwdata[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg <= '0;
        end
        else
        begin
            term_reg <= term_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_TERMINATOR)
        begin
            prdata = APB_DW'(term_reg);
        end
    end

    assign terminator = term_reg;

endmodule

`default_nettype wire
